// ----- rtl/core/tbcpu_pkg.sv -----
// Shared types and constants for the twelve-bit memory-reference processor.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none
package tbcpu_pkg;

  // Item kinds carried on the input tuser
  localparam logic [1:0] KIND_EXEC  = 2'd0;
  localparam logic [1:0] KIND_IRQ   = 2'd1;
  localparam logic [1:0] KIND_WRITE = 2'd2;
  localparam logic [1:0] KIND_READ  = 2'd3;

  // Major opcodes, instruction bits 11:9
  localparam logic [2:0] OP_AND = 3'd0;
  localparam logic [2:0] OP_TAD = 3'd1;
  localparam logic [2:0] OP_ISZ = 3'd2;
  localparam logic [2:0] OP_DCA = 3'd3;
  localparam logic [2:0] OP_JMS = 3'd4;
  localparam logic [2:0] OP_JMP = 3'd5;
  localparam logic [2:0] OP_IOT = 3'd6;
  localparam logic [2:0] OP_OPR = 3'd7;

  // Word constants
  localparam logic [11:0] WORD_ONES  = 12'o7777;
  localparam logic [11:0] RESET_PC   = 12'o7777;
  localparam logic [11:0] IRQ_VECTOR = 12'o0001;
  localparam logic [11:0] IRQ_SAVE   = 12'o0000;
  localparam logic [8:0]  AUTO_PAGE  = 9'o001;   // words 0010-0017
  localparam logic [15:0] CPF_RESET  = 16'd16666;

  // Cycle costs of the indirect forms
  localparam logic [4:0] CYC_INDIRECT = 5'd5;
  localparam logic [4:0] CYC_AUTO     = 5'd6;

  // Datapath commands, one per controller step
  localparam logic [3:0] CMD_NONE     = 4'd0;
  localparam logic [3:0] CMD_MEM_WR   = 4'd1;
  localparam logic [3:0] CMD_MEM_RD   = 4'd2;
  localparam logic [3:0] CMD_RD_CAP   = 4'd3;
  localparam logic [3:0] CMD_FETCH    = 4'd4;
  localparam logic [3:0] CMD_DECODE   = 4'd5;
  localparam logic [3:0] CMD_DISPATCH = 4'd6;
  localparam logic [3:0] CMD_IND_RD   = 4'd7;
  localparam logic [3:0] CMD_IND_CAP  = 4'd8;
  localparam logic [3:0] CMD_IND_WR   = 4'd9;
  localparam logic [3:0] CMD_EXEC     = 4'd10;
  localparam logic [3:0] CMD_OP_CAP   = 4'd11;
  localparam logic [3:0] CMD_ISZ_WR   = 4'd12;
  localparam logic [3:0] CMD_INTR     = 4'd13;
  localparam logic [3:0] CMD_CYCLE    = 4'd14;

  typedef struct packed {
    logic [3:0] op;
    logic       item_load;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic [2:0] opcode;
    logic       indirect;
    logic       autoindex;
  } stat_t;

  // Base cycle cost of each major opcode
  function automatic logic [4:0] cycle_base(input logic [2:0] opcode);
    logic [4:0] c;
    unique case (opcode)
      OP_AND, OP_TAD, OP_JMP, OP_OPR: c = 5'd10;
      OP_ISZ:                         c = 5'd16;
      OP_DCA, OP_JMS:                 c = 5'd11;
      default:                        c = 5'd0;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/tbcpu_ctrl.sv -----
// Sequencing state machine for the twelve-bit processor.
// Depends on tbcpu_pkg for commands and status; drives the datapath and the handshakes.
`default_nettype none
module tbcpu_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  input  logic [1:0]         s_tuser,
  output logic               s_tready,
  input  logic               m_tready,
  output logic               m_tvalid,
  input  tbcpu_pkg::stat_t   stat,
  output tbcpu_pkg::cmd_t    cmd
);
  import tbcpu_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_MEM_WR   = 4'd1;
  localparam logic [3:0] S_MEM_RD   = 4'd2;
  localparam logic [3:0] S_RD_CAP   = 4'd3;
  localparam logic [3:0] S_FETCH    = 4'd4;
  localparam logic [3:0] S_DECODE   = 4'd5;
  localparam logic [3:0] S_DISPATCH = 4'd6;
  localparam logic [3:0] S_IND_RD   = 4'd7;
  localparam logic [3:0] S_IND_CAP  = 4'd8;
  localparam logic [3:0] S_IND_WR   = 4'd9;
  localparam logic [3:0] S_EXEC     = 4'd10;
  localparam logic [3:0] S_OP_CAP   = 4'd11;
  localparam logic [3:0] S_ISZ_WR   = 4'd12;
  localparam logic [3:0] S_INTR     = 4'd13;
  localparam logic [3:0] S_CYCLE    = 4'd14;
  localparam logic [3:0] S_DONE     = 4'd15;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       accept;
  logic       out_free;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // Choose the next step
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (s_tuser)
            KIND_EXEC:  state_next = S_FETCH;
            KIND_IRQ:   state_next = S_DONE;
            KIND_WRITE: state_next = S_MEM_WR;
            default:    state_next = S_MEM_RD;
          endcase
        end
      end
      S_MEM_WR:   state_next = S_DONE;
      S_MEM_RD:   state_next = S_RD_CAP;
      S_RD_CAP:   state_next = S_DONE;
      S_FETCH:    state_next = S_DECODE;
      S_DECODE:   state_next = S_DISPATCH;
      S_DISPATCH: begin
        if (stat.opcode == OP_IOT || stat.opcode == OP_OPR) begin
          state_next = S_INTR;
        end else if (stat.indirect) begin
          state_next = S_IND_RD;
        end else begin
          state_next = S_EXEC;
        end
      end
      S_IND_RD:   state_next = S_IND_CAP;
      S_IND_CAP:  state_next = stat.autoindex ? S_IND_WR : S_EXEC;
      S_IND_WR:   state_next = S_EXEC;
      S_EXEC: begin
        if (stat.opcode == OP_AND || stat.opcode == OP_TAD || stat.opcode == OP_ISZ) begin
          state_next = S_OP_CAP;
        end else begin
          state_next = S_INTR;
        end
      end
      S_OP_CAP:   state_next = (stat.opcode == OP_ISZ) ? S_ISZ_WR : S_INTR;
      S_ISZ_WR:   state_next = S_INTR;
      S_INTR:     state_next = S_CYCLE;
      S_CYCLE:    state_next = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default:    state_next = S_IDLE;
    endcase
  end

  // Map each step to its datapath command
  always_comb begin
    cmd.item_load = accept;
    cmd.out_load  = (state == S_DONE) && out_free;
    unique case (state)
      S_MEM_WR:   cmd.op = CMD_MEM_WR;
      S_MEM_RD:   cmd.op = CMD_MEM_RD;
      S_RD_CAP:   cmd.op = CMD_RD_CAP;
      S_FETCH:    cmd.op = CMD_FETCH;
      S_DECODE:   cmd.op = CMD_DECODE;
      S_DISPATCH: cmd.op = CMD_DISPATCH;
      S_IND_RD:   cmd.op = CMD_IND_RD;
      S_IND_CAP:  cmd.op = CMD_IND_CAP;
      S_IND_WR:   cmd.op = CMD_IND_WR;
      S_EXEC:     cmd.op = CMD_EXEC;
      S_OP_CAP:   cmd.op = CMD_OP_CAP;
      S_ISZ_WR:   cmd.op = CMD_ISZ_WR;
      S_INTR:     cmd.op = CMD_INTR;
      S_CYCLE:    cmd.op = CMD_CYCLE;
      default:    cmd.op = CMD_NONE;
    endcase
  end

  // Advance state; hold the result valid until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/tbcpu_dp.sv -----
// Datapath of the twelve-bit processor: registers, main memory, adders.
// Depends on tbcpu_pkg; acts on commands from tbcpu_ctrl and on cfg_* writes.
`default_nettype none
module tbcpu_dp #(
  parameter int MEMORY_WORDS = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  tbcpu_pkg::cmd_t    cmd,
  output tbcpu_pkg::stat_t   stat,
  input  logic [1:0]         s_tuser,
  input  logic [23:0]        s_tdata,
  input  logic               cfg_valid,
  input  logic [15:0]        cfg_data,
  output logic [39:0]        m_tdata
);
  import tbcpu_pkg::*;

  localparam int AW = $clog2(MEMORY_WORDS);

  // Architectural state
  logic [11:0] pc;
  logic [11:0] acc;
  logic        link;
  logic        pending;
  logic [15:0] count;
  logic [15:0] cpf;

  // Per-item working registers
  logic [11:0] addr_q;
  logic [11:0] data_q;
  logic [11:0] here;
  logic [11:0] ir;
  logic [11:0] ea;
  logic [11:0] ptr;
  logic [4:0]  cyc;
  logic        done_q;
  logic [11:0] rd_q;

  // Memory port
  logic [11:0] mem [MEMORY_WORDS];
  logic [11:0] rdata;
  logic [11:0] maddr;
  logic [11:0] wdata;
  logic        we;
  logic [AW-1:0] midx;

  logic [12:0] tad_sum;
  logic [16:0] cyc_sum;
  logic [16:0] cyc_diff;

  // Reduce a word address modulo the memory size
  function automatic logic [AW-1:0] wrap_addr(input logic [11:0] a);
    logic [16:0] v;
    v = {5'd0, a};
    for (int k = 3; k >= 0; k--) begin
      if (v >= 17'(MEMORY_WORDS << k)) begin
        v = v - 17'(MEMORY_WORDS << k);
      end
    end
    return v[AW-1:0];
  endfunction

  assign stat.opcode    = ir[11:9];
  assign stat.indirect  = ir[8];
  assign stat.autoindex = (ea[11:3] == AUTO_PAGE);

  // Select the memory address and write data for this step
  always_comb begin
    maddr = ea;
    wdata = ptr;
    we    = 1'b0;
    unique case (cmd.op)
      CMD_MEM_WR: begin
        maddr = addr_q;
        wdata = data_q;
        we    = 1'b1;
      end
      CMD_MEM_RD: maddr = addr_q;
      CMD_FETCH:  maddr = pc;
      CMD_IND_WR: we = 1'b1;
      CMD_ISZ_WR: we = 1'b1;
      CMD_EXEC: begin
        if (ir[11:9] == OP_DCA) begin
          wdata = acc;
          we    = 1'b1;
        end else if (ir[11:9] == OP_JMS) begin
          wdata = pc;
          we    = 1'b1;
        end
      end
      CMD_INTR: begin
        maddr = IRQ_SAVE;
        wdata = pc;
        we    = pending;
      end
      default: ;
    endcase
  end

  assign midx = wrap_addr(maddr);

  // Single-port memory with registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[midx] <= wdata;
    end
    rdata <= mem[midx];
  end

  assign tad_sum  = {1'b0, acc} + {1'b0, rdata};
  assign cyc_sum  = {1'b0, count} + 17'(cyc);
  assign cyc_diff = cyc_sum - {1'b0, cpf};

  // Architectural registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pc      <= RESET_PC;
      acc     <= '0;
      link    <= 1'b0;
      pending <= 1'b0;
      count   <= '0;
      cpf     <= CPF_RESET;
    end else begin
      if (cfg_valid) begin
        cpf <= cfg_data;
      end
      if (cmd.item_load && s_tuser == KIND_IRQ) begin
        pending <= 1'b1;
      end
      unique case (cmd.op)
        CMD_FETCH: pc <= pc + 12'd1;
        CMD_EXEC: begin
          if (ir[11:9] == OP_DCA) begin
            acc <= '0;
          end else if (ir[11:9] == OP_JMS) begin
            pc <= ea + 12'd1;
          end else if (ir[11:9] == OP_JMP) begin
            pc <= ea;
          end
        end
        CMD_OP_CAP: begin
          if (ir[11:9] == OP_AND) begin
            acc <= acc & rdata;
          end else if (ir[11:9] == OP_TAD) begin
            acc <= tad_sum[11:0];
            link <= link ^ tad_sum[12];
          end else if (rdata == WORD_ONES) begin
            pc <= pc + 12'd1;
          end
        end
        CMD_INTR: begin
          if (pending) begin
            pc      <= IRQ_VECTOR;
            pending <= 1'b0;
          end
        end
        CMD_CYCLE: begin
          if (cyc_sum < {1'b0, cpf}) begin
            count <= cyc_sum[15:0];
          end else begin
            count <= cyc_diff[16] ? 16'hFFFF : cyc_diff[15:0];
          end
        end
        default: ;
      endcase
    end
  end

  // Working registers; no reset needed
  always_ff @(posedge clk) begin
    if (cmd.item_load) begin
      addr_q <= s_tdata[11:0];
      data_q <= s_tdata[23:12];
      done_q <= 1'b0;
      rd_q   <= '0;
    end
    unique case (cmd.op)
      CMD_RD_CAP: rd_q <= rdata;
      CMD_FETCH:  here <= pc;
      CMD_DECODE: begin
        ir <= rdata;
        ea <= {(rdata[7] ? here[11:7] : 5'd0), rdata[6:0]};
      end
      CMD_DISPATCH: cyc <= cycle_base(ir[11:9]);
      CMD_IND_CAP: begin
        if (stat.autoindex) begin
          ptr <= rdata + 12'd1;
          cyc <= cyc + CYC_AUTO;
        end else begin
          ea  <= rdata;
          cyc <= cyc + CYC_INDIRECT;
        end
      end
      CMD_IND_WR: ea <= ptr;
      CMD_OP_CAP: ptr <= rdata + 12'd1;
      CMD_CYCLE:  done_q <= !(cyc_sum < {1'b0, cpf});
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= {2'b00, rd_q, done_q, link, acc, pc};
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/twelve_bit_memory_reference_cpu.sv -----
// Top level of the twelve-bit memory-reference processor.
// Instantiates tbcpu_ctrl and tbcpu_dp; types and constants from tbcpu_pkg.
//
//   channel   signals                      payload
//   s_*       s_tvalid s_tready s_tuser    kind; tdata: address, data
//   m_*       m_tvalid m_tready            tdata: pc, accumulator, link,
//                                          frame_done, read_data
//   cfg_*     cfg_valid cfg_ready          frame length in machine cycles
//
// One item at a time. Execute items step through fetch, optional indirect read and
// auto-index write, operand access, interrupt save and cycle count, bounded by the
// single memory port. Reset is synchronous; memory contents are not cleared. A new
// item is taken while a result waits; the block then stalls before loading the next
// result.
`default_nettype none
module twelve_bit_memory_reference_cpu #(
  parameter int MEMORY_WORDS = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [11:0] address, [23:12] data
  input  logic [1:0]  s_tuser,   // [1:0] kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [11:0] pc, [23:12] accumulator, [24] link,
                                 // [25] frame_done, [37:26] read_data, [39:38] zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data   // frame length in machine cycles
);
  import tbcpu_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  tbcpu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tuser  (s_tuser),
    .s_tready (s_tready),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .stat     (stat),
    .cmd      (cmd)
  );

  tbcpu_dp #(
    .MEMORY_WORDS (MEMORY_WORDS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .s_tuser   (s_tuser),
    .s_tdata   (s_tdata),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .m_tdata   (m_tdata)
  );

`ifndef SYNTH
  // An accepted item always keeps the block busy in the cycle after the accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken again right after an accept");

  // A result appears only at the end of work on an item
  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("result raised while idle");

  // A result is dropped only after it was taken
  a_result_taken: assert property (@(posedge clk) disable iff (rst)
    $fell(m_tvalid) |-> $past(m_tready))
    else $error("result dropped without handshake");
`endif

endmodule
`default_nettype wire

// ----- verif/tb_top.sv -----
// Self-checking testbench for twelve_bit_memory_reference_cpu.
// Drives instruction, interrupt, memory write and memory read items and checks
// every result against a cycle-free shadow of the processor; needs tbcpu_pkg.
module tb_top;
  import tbcpu_pkg::*;

  localparam int          CYCLE_LIMIT    = 600000;
  localparam int          RX_HOLD_CYCLES = 300;
  localparam int          DRAIN_CYCLES   = 16;
  localparam logic [11:0] INDIRECT_BIT   = 12'o0400;

  // One result as it appears on m_tdata, lowest field last
  typedef struct packed {
    logic [1:0]  pad;
    logic [11:0] read_data;
    logic        frame_done;
    logic        link_bit;
    logic [11:0] acc;
    logic [11:0] pc;
  } cpu_result_t;

  // Shadow processor: tracks memory and registers, queues the results it predicts
  class cpu_shadow;
    logic [11:0]  mem [4096];
    bit           written [4096];
    int           written_list[$];
    logic [11:0]  pc = RESET_PC;
    logic [11:0]  acc = '0;
    logic         link_bit = 1'b0;
    logic         irq_pending = 1'b0;
    int           cycles = 0;
    int           frame_len = CPF_RESET;
    int           item_total = 0;
    int           fail_count = 0;
    cpu_result_t  expected_results[$];

    function void put(logic [11:0] addr, logic [11:0] value);
      mem[addr] = value;
      if (!written[addr]) begin
        written[addr] = 1'b1;
        written_list.push_back(addr);
      end
    endfunction

    // Effective address and indirect cycle cost; with apply set, store the bumped auto-index pointer
    function logic [11:0] target(logic [11:0] ir, logic [11:0] here, bit apply,
                                 inout int cyc);
      logic [11:0] ea;
      logic [11:0] ptr;
      ea = {5'd0, ir[6:0]};
      if (ir[7]) ea[11:7] = here[11:7];
      if (ir[8]) begin
        ptr = mem[ea];
        if (ea[11:3] == AUTO_PAGE) begin
          ptr = ptr + 12'd1;
          if (apply) put(ea, ptr);
          cyc += CYC_AUTO;
        end else begin
          cyc += CYC_INDIRECT;
        end
        ea = ptr;
      end
      return ea;
    endfunction

    // Fetch and run one instruction, service the interrupt, count cycles
    function bit run_instruction();
      logic [11:0] here;
      logic [11:0] ir;
      logic [11:0] ea;
      logic [11:0] v;
      logic [12:0] sum13;
      int          cyc;
      int          total;
      here = pc;
      ir   = mem[here];
      pc   = here + 12'd1;
      cyc  = 0;
      ea   = '0;
      if (ir[11:9] <= OP_JMP) ea = target(ir, here, 1'b1, cyc);
      case (ir[11:9])
        OP_AND: begin
          acc = acc & mem[ea];
          cyc += 10;
        end
        OP_TAD: begin
          sum13 = {1'b0, acc} + {1'b0, mem[ea]};
          if (sum13[12]) link_bit = ~link_bit;
          acc = sum13[11:0];
          cyc += 10;
        end
        OP_ISZ: begin
          v = mem[ea] + 12'd1;
          put(ea, v);
          if (v == 12'd0) pc = pc + 12'd1;
          cyc += 16;
        end
        OP_DCA: begin
          put(ea, acc);
          acc = '0;
          cyc += 11;
        end
        OP_JMS: begin
          put(ea, pc);
          pc = ea + 12'd1;
          cyc += 11;
        end
        OP_JMP: begin
          pc = ea;
          cyc += 10;
        end
        OP_OPR: cyc += 10;
        default: ;  // IOT does nothing and costs nothing
      endcase
      if (irq_pending) begin
        irq_pending = 1'b0;
        put(IRQ_SAVE, pc);
        pc = IRQ_VECTOR;
      end
      total = cycles + cyc;
      if (total < frame_len) begin
        cycles = total;
        return 1'b0;
      end
      total -= frame_len;
      cycles = (total > 65535) ? 65535 : total;
      return 1'b1;
    endfunction

    function void note_item(logic [1:0] kind, logic [11:0] addr, logic [11:0] data);
      cpu_result_t r;
      r = '0;
      case (kind)
        KIND_EXEC:  r.frame_done = run_instruction();
        KIND_IRQ:   irq_pending = 1'b1;
        KIND_WRITE: put(addr, data);
        KIND_READ:  r.read_data = mem[addr];
        default: ;
      endcase
      r.pc       = pc;
      r.acc      = acc;
      r.link_bit = link_bit;
      expected_results.push_back(r);
      item_total++;
    endfunction

    function void check_result(logic [39:0] raw);
      cpu_result_t got;
      cpu_result_t want;
      got = raw;
      if (expected_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("result %h with nothing outstanding", raw);
        return;
      end
      want = expected_results.pop_front();
      if (got.pc != want.pc || got.acc != want.acc || got.link_bit != want.link_bit ||
          got.frame_done != want.frame_done || got.read_data != want.read_data) begin
        fail_count++;
        if (fail_count <= 10)
          $display("mismatch exp/got: pc %o/%o acc %o/%o link %0d/%0d frame %0d/%0d rd %o/%o",
                   want.pc, got.pc, want.acc, got.acc, want.link_bit, got.link_bit,
                   want.frame_done, got.frame_done, want.read_data, got.read_data);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;   // [11:0] address, [23:12] data
  logic [1:0]  s_tuser;   // [1:0] kind
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;   // [11:0] pc, [23:12] accumulator, [24] link,
                          // [25] frame_done, [37:26] read_data
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;

  cpu_shadow sb = new;
  bit        idle_on = 1'b1;
  bit        hold_req = 1'b0;
  int        tx_busy = 15;
  int        cycle_cnt = 0;

  twelve_bit_memory_reference_cpu u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Check every accepted result; end the run at the cycle limit
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request
  initial begin : rx_side
    int n;
    int rx_busy;
    rx_busy = 10;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 63) == 0) rx_busy = ($urandom_range(0, 2) == 0) ? 0 : 25;
      if (hold_req) begin
        m_tready = 1'b0;
        repeat (RX_HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 99) < rx_busy) begin
        n = $urandom_range(1, 14);
        m_tready = 1'b0;
        repeat (n - 1) @(negedge clk);
      end else begin
        m_tready = 1'b1;
      end
    end
  end

  // Offer one item from a falling edge, note it when taken, return at a falling edge
  task automatic send_item(input logic [1:0] kind, input logic [11:0] addr,
                           input logic [11:0] data);
    if ($urandom_range(0, 49) == 0) tx_busy = ($urandom_range(0, 2) == 0) ? 0 : 20;
    if (idle_on && $urandom_range(0, 99) < tx_busy) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    s_tuser  = kind;
    s_tdata  = {data, addr};
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    sb.note_item(kind, addr, data);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    s_tvalid = 1'b0;
    do @(negedge clk); while (sb.expected_results.size() != 0);
  endtask

  task automatic set_frame_length(input logic [15:0] value);
    wait_drained();
    cfg_data  = value;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    sb.frame_len = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [11:0] special_word();
    case ($urandom_range(0, 7))
      0:       return 12'o0000;
      1:       return WORD_ONES;
      2:       return 12'o7776;
      3:       return 12'o0001;
      default: return 12'($urandom_range(0, 4095));
    endcase
  endfunction

  function automatic logic [11:0] random_instr();
    logic [11:0] ir;
    ir = 12'($urandom_range(0, 4095));
    // favor the auto-index pointers
    if ($urandom_range(0, 3) == 0) begin
      ir[8:7] = 2'b10;
      ir[6:0] = 7'o10 + 7'($urandom_range(0, 7));
    end
    return ir;
  endfunction

  // Place an instruction at pc, make every word it reads defined, then run it.
  // With fixed set the given instruction, pointer and operand are stored.
  task automatic run_at_pc(input bit fixed, input logic [11:0] ir_f,
                           input logic [11:0] ptr_f, input logic [11:0] opnd_f);
    logic [11:0] here;
    logic [11:0] ir;
    logic [11:0] pa;
    logic [11:0] ea;
    int          cyc;
    here = sb.pc;
    pa   = here;
    cyc  = 0;
    if (fixed) send_item(KIND_WRITE, here, ir_f);
    else if ($urandom_range(0, 3) != 0 || !sb.written[here])
      send_item(KIND_WRITE, here, random_instr());
    ir = sb.mem[here];
    if (ir[11:9] <= OP_JMP && ir[8]) begin
      pa = sb.target(ir & ~INDIRECT_BIT, here, 1'b0, cyc);
      if (!sb.written[pa] || (pa != here && (fixed || $urandom_range(0, 2) == 0)))
        send_item(KIND_WRITE, pa, fixed ? ptr_f : special_word());
    end
    if (ir[11:9] <= OP_ISZ) begin
      ea = sb.target(ir, here, 1'b0, cyc);
      if (!sb.written[ea] ||
          (ea != here && ea != pa && (fixed || $urandom_range(0, 1) == 0)))
        send_item(KIND_WRITE, ea, fixed ? opnd_f : special_word());
    end
    send_item(KIND_EXEC, 12'($urandom), 12'($urandom));
  endtask

  task automatic random_step();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      run_at_pc(1'b0, '0, '0, '0);
    end else if (r < 63) begin
      send_item(KIND_IRQ, 12'($urandom), 12'($urandom));
    end else if (r < 80 || sb.written_list.size() == 0) begin
      send_item(KIND_WRITE, 12'($urandom), 12'($urandom));
    end else begin
      send_item(KIND_READ,
                12'(sb.written_list[$urandom_range(0, sb.written_list.size() - 1)]),
                12'($urandom));
    end
  endtask

  initial begin
    int          goals [4];
    int          ph;
    bit          paused;
    logic [15:0] frame_value;
    goals     = '{450, 850, 1250, 1560};
    paused    = 1'b0;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = KIND_EXEC;
    m_tready  = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: memory extremes, every opcode, each addressing form, interrupt
    send_item(KIND_WRITE, 12'o0000, 12'o0000);
    send_item(KIND_WRITE, 12'o7777, WORD_ONES);
    send_item(KIND_READ, 12'o7777, 12'o0000);
    send_item(KIND_EXEC, WORD_ONES, WORD_ONES);                       // operate, pc wraps
    run_at_pc(1'b1, {OP_TAD, 2'b00, 7'o100}, '0, 12'o7776);          // page zero
    run_at_pc(1'b1, {OP_TAD, 2'b01, 7'o101}, '0, 12'o0003);          // carry flips link
    run_at_pc(1'b1, {OP_ISZ, 2'b10, 7'o017}, 12'o7776, WORD_ONES);   // auto-index, skip
    run_at_pc(1'b1, {OP_JMP, 2'b10, 7'o020}, 12'o4321, '0);          // plain indirect
    run_at_pc(1'b1, {OP_AND, 2'b01, 7'o005}, '0, 12'o5555);          // current page
    send_item(KIND_IRQ, '0, '0);
    run_at_pc(1'b1, {OP_JMS, 2'b01, 7'o150}, '0, '0);                // then interrupt
    run_at_pc(1'b1, {OP_DCA, 2'b00, 7'o177}, '0, '0);
    run_at_pc(1'b1, {OP_IOT, 9'o777}, '0, '0);

    // Random phases, one frame length each; no idling in the last
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       frame_value = 16'd1;
        1:       frame_value = 16'hFFFF;
        2:       frame_value = 16'($urandom_range(20, 400));
        default: frame_value = 16'($urandom_range(30, 3000));
      endcase
      set_frame_length(frame_value);
      idle_on = (ph != 3);
      if (ph == 1) hold_req = 1'b1;
      while (sb.item_total < goals[ph]) begin
        if (ph == 2 && !paused && sb.item_total >= goals[ph] - 200) begin
          wait_drained();
          paused = 1'b1;
        end
        random_step();
      end
    end

    // Drain and report
    s_tvalid = 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.fail_count == 0 && sb.expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
